// ----- rtl/bote_pkg.sv -----
package bote_pkg;

   localparam int DEFAULT_BLOCK_COUNT = 512;
   localparam int DEFAULT_ENTRY_COUNT = 96;

   localparam int OP_W     = 3;
   localparam int BLK_W    = 9;
   localparam int OWNER_W  = 8;
   localparam int RES_W    = 8;
   localparam int WORD16_W = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 10;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE_OWNER = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE_ENTRY = 3'd1;
   localparam logic [OP_W-1:0] OP_RELEASE     = 3'd2;
   localparam logic [OP_W-1:0] OP_RESET_ENTRY = 3'd3;
   localparam logic [OP_W-1:0] OP_ACTIVATE    = 3'd4;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_IDX  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RELEASED = 2'd2;

   localparam logic [OWNER_W-1:0]  FREE_MARK      = 8'hFF;
   localparam logic [WORD16_W-1:0] FLAGS_IDLE     = 16'hFFFF;
   localparam logic [WORD16_W-1:0] ACTIVATE_LIMIT = 16'd16;
   localparam logic [COUNT_W-1:0]  COUNT_MAX      = 10'd1023;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic clear_pass;  // write free mark at scan address
      logic capture;     // latch request word, read entry table
      logic apply;       // act on entry or owner map, start a scan
      logic scan_issue;  // read owner map at scan address
   } cmd_type;

   typedef struct packed {
      logic scan_last;   // scan address at last block
   } stat_type;

endpackage

// ----- rtl/block_owner_table_engine.sv -----
// Block owner table engine.
// Holds one owner byte per block (0xFF = free) and a table of resource
// entries (16-bit value, 16-bit flags). Each request word carries one op:
// write owner, write entry, release owner, reset entry or activate entry.
// Request channel: a word is taken at a clock edge with start high and busy
// low; busy stays high until the result has been presented.
// Result channel: one word per request, valid for exactly one cycle while
// rsp_strobe is high. The receiver cannot stall; it must take it then.
// Timing: a taken request passes through the lookup, scan, drain and done
// states; rsp_strobe is high in done, busy drops at the edge that takes the
// result, and the next request is taken only once busy is low, so a new
// request waits for the last result. The owner-map scan fills most of the
// busy window: every op walks all blocks, one owner-map read per cycle,
// releasing the owner's blocks and tracking the longest free run in one pass.
// Reset: the entry table reads as reset values through per-entry valid
// bits; the owner map is swept to free, block by block, after reset,
// with busy high, before the first request is taken.
module block_owner_table_engine import bote_pkg::*; #(
   parameter int BLOCK_COUNT = DEFAULT_BLOCK_COUNT,
   parameter int ENTRY_COUNT = DEFAULT_ENTRY_COUNT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [OP_W-1:0]     req_op,
   input  logic [BLK_W-1:0]    req_block_index,
   input  logic [OWNER_W-1:0]  req_owner_byte,
   input  logic [RES_W-1:0]    req_resource_index,
   input  logic [WORD16_W-1:0] req_entry_value_in,
   input  logic [WORD16_W-1:0] req_entry_flags_in,
   output logic                rsp_strobe,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_freed_count,
   output logic [COUNT_W-1:0]  rsp_longest_free_run
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer: clearing pass, lookup, scan, drain, respond
   bote_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   // owner map, entry table, scan counters
   bote_dp #(
      .BLOCK_COUNT (BLOCK_COUNT),
      .ENTRY_COUNT (ENTRY_COUNT)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .req_op               (req_op),
      .req_block_index      (req_block_index),
      .req_owner_byte       (req_owner_byte),
      .req_resource_index   (req_resource_index),
      .req_entry_value_in   (req_entry_value_in),
      .req_entry_flags_in   (req_entry_flags_in),
      .rsp_status           (rsp_status),
      .rsp_freed_count      (rsp_freed_count),
      .rsp_longest_free_run (rsp_longest_free_run)
   );

   // a result word only appears inside a busy window
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside busy window");

   // a taken request keeps the engine busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // release status needs at least one freed block
   a_release_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == STATUS_RELEASED)) |-> (rsp_freed_count != '0))
      else $error("release status with zero freed count");

   // freed blocks are free afterward, so some free run exists
   a_freed_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_freed_count != '0)) |-> (rsp_longest_free_run != '0))
      else $error("blocks freed but no free run reported");

endmodule

// ----- rtl/bote_ctrl.sv -----
module bote_ctrl import bote_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     rsp_strobe
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_pass = 1'b1;
            if (stat.scan_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            cmd.apply = 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_strobe = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/bote_dp.sv -----
module bote_dp import bote_pkg::*; #(
   parameter int BLOCK_COUNT = DEFAULT_BLOCK_COUNT,
   parameter int ENTRY_COUNT = DEFAULT_ENTRY_COUNT
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [OP_W-1:0]     req_op,
   input  logic [BLK_W-1:0]    req_block_index,
   input  logic [OWNER_W-1:0]  req_owner_byte,
   input  logic [RES_W-1:0]    req_resource_index,
   input  logic [WORD16_W-1:0] req_entry_value_in,
   input  logic [WORD16_W-1:0] req_entry_flags_in,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_freed_count,
   output logic [COUNT_W-1:0]  rsp_longest_free_run
);

   localparam int BAW = $clog2(BLOCK_COUNT);
   localparam int EAW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
   localparam int CW  = $clog2(BLOCK_COUNT + 1);
   localparam int EW  = 2 * WORD16_W;

   // owner map and entry table
   logic [OWNER_W-1:0] owner_mem [BLOCK_COUNT];
   logic [EW-1:0]      entry_mem [ENTRY_COUNT];

   // latched request word
   logic [OP_W-1:0]     op_ff;
   logic [BLK_W-1:0]    blk_ff;
   logic [OWNER_W-1:0]  own_ff;
   logic [RES_W-1:0]    idx_ff;
   logic [WORD16_W-1:0] val_ff;
   logic [WORD16_W-1:0] flg_ff;

   logic [EW-1:0]            ent_rd_ff;
   logic                     ent_rd_valid_ff;
   logic [ENTRY_COUNT-1:0]   entry_valid_ff;
   logic [BAW-1:0]           scan_addr_ff;
   logic [BAW-1:0]           scan_addr_in;
   logic [OWNER_W-1:0]       owner_rd_ff;
   logic                     proc_valid_ff;
   logic [BAW-1:0]           proc_addr_ff;
   logic                     release_en_ff;
   logic                     release_in;
   logic [CW-1:0]            cur_ff;
   logic [CW-1:0]            cur_in;
   logic [CW-1:0]            best_ff;
   logic [CW-1:0]            freed_ff;

   logic                     req_idx_in_range;
   logic                     idx_ok;
   logic                     op_uses_idx;
   logic                     blk_ok;
   logic [WORD16_W-1:0]      val_cur;
   logic [WORD16_W-1:0]      flg_cur;
   logic                     cond_reset;
   logic                     cond_act;
   logic                     ent_we;
   logic [EW-1:0]            ent_wd;
   logic [EAW-1:0]           ent_addr;
   logic                     own_we;
   logic [BAW-1:0]           own_wa;
   logic [OWNER_W-1:0]       own_wd;
   logic                     match;
   logic                     is_free;

   assign stat.scan_last = (scan_addr_ff == BAW'(BLOCK_COUNT - 1));

   assign req_idx_in_range = ({1'b0, req_resource_index} < 9'(ENTRY_COUNT));
   assign idx_ok           = ({1'b0, idx_ff} < 9'(ENTRY_COUNT));
   assign op_uses_idx      = (op_ff >= OP_WRITE_ENTRY) && (op_ff <= OP_ACTIVATE);
   assign blk_ok           = (32'(blk_ff) < 32'(BLOCK_COUNT));
   assign ent_addr         = EAW'(idx_ff);

   // request capture and entry read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff           <= req_op;
         blk_ff          <= req_block_index;
         own_ff          <= req_owner_byte;
         idx_ff          <= req_resource_index;
         val_ff          <= req_entry_value_in;
         flg_ff          <= req_entry_flags_in;
         ent_rd_ff       <= entry_mem[EAW'(req_resource_index)];
         ent_rd_valid_ff <= req_idx_in_range &&
                            entry_valid_ff[EAW'(req_resource_index)];
      end
   end

   // entries never written read as value 0, flags idle
   assign val_cur    = ent_rd_valid_ff ? ent_rd_ff[WORD16_W-1:0] : '0;
   assign flg_cur    = ent_rd_valid_ff ? ent_rd_ff[EW-1:WORD16_W] : FLAGS_IDLE;
   assign cond_reset = (flg_cur != FLAGS_IDLE);
   assign cond_act   = (val_cur > ACTIVATE_LIMIT);

   always_comb begin
      release_in = 1'b0;
      ent_we     = 1'b0;
      ent_wd     = {flg_ff, val_ff};
      unique case (op_ff)
         OP_WRITE_ENTRY: begin
            ent_we = 1'b1;
         end
         OP_RELEASE: begin
            release_in = 1'b1;
         end
         OP_RESET_ENTRY: begin
            release_in = cond_reset;
            ent_we     = cond_reset;
            ent_wd     = {FLAGS_IDLE, WORD16_W'(0)};
         end
         OP_ACTIVATE: begin
            release_in = cond_act;
            ent_we     = cond_act;
            ent_wd     = {flg_cur, WORD16_W'(1)};
         end
         default: begin
            release_in = 1'b0;
         end
      endcase
      release_in = release_in && idx_ok;
      ent_we     = ent_we && idx_ok && cmd.apply;
   end

   always_ff @(posedge clock) begin
      if (ent_we) entry_mem[ent_addr] <= ent_wd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (ent_we) begin
         entry_valid_ff[ent_addr] <= 1'b1;
      end
   end

   // scan address: clearing pass and owner scan
   always_comb begin
      scan_addr_in = scan_addr_ff;
      if (cmd.apply) begin
         scan_addr_in = '0;
      end else if (cmd.clear_pass || cmd.scan_issue) begin
         scan_addr_in = stat.scan_last ? '0 : scan_addr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff  <= '0;
         proc_valid_ff <= 1'b0;
      end else begin
         scan_addr_ff  <= scan_addr_in;
         proc_valid_ff <= cmd.scan_issue;
      end
   end

   always_ff @(posedge clock) begin
      owner_rd_ff  <= owner_mem[scan_addr_ff];
      proc_addr_ff <= scan_addr_ff;
   end

   assign match   = proc_valid_ff && release_en_ff && (owner_rd_ff == idx_ff);
   assign is_free = (owner_rd_ff == FREE_MARK) || match;
   assign cur_in  = is_free ? cur_ff + 1'b1 : '0;

   // owner map write port
   always_comb begin
      own_we = 1'b0;
      own_wa = proc_addr_ff;
      own_wd = FREE_MARK;
      if (cmd.clear_pass) begin
         own_we = 1'b1;
         own_wa = scan_addr_ff;
      end else if (cmd.apply && (op_ff == OP_WRITE_OWNER) && blk_ok) begin
         own_we = 1'b1;
         own_wa = BAW'(blk_ff);
         own_wd = own_ff;
      end else if (match) begin
         own_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (own_we) owner_mem[own_wa] <= own_wd;
   end

   // run and release counters
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         release_en_ff <= release_in;
         cur_ff        <= '0;
         best_ff       <= '0;
         freed_ff      <= '0;
      end else if (proc_valid_ff) begin
         cur_ff <= cur_in;
         if (cur_in > best_ff) best_ff <= cur_in;
         if (match) freed_ff <= freed_ff + 1'b1;
      end
   end

   always_comb begin
      if (op_uses_idx && !idx_ok) begin
         rsp_status = STATUS_BAD_IDX;
      end else if ((op_ff == OP_RELEASE) && (freed_ff != '0)) begin
         rsp_status = STATUS_RELEASED;
      end else begin
         rsp_status = STATUS_OK;
      end
   end

   assign rsp_freed_count      = (32'(freed_ff) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                                  : COUNT_W'(freed_ff);
   assign rsp_longest_free_run = (32'(best_ff) > 32'(COUNT_MAX)) ? COUNT_MAX
                                                                 : COUNT_W'(best_ff);

endmodule

// ----- test/tb_block_owner_table_engine.sv -----
module tb_block_owner_table_engine;
   import bote_pkg::*;

   localparam int BLOCKS  = DEFAULT_BLOCK_COUNT;
   localparam int ENTRIES = DEFAULT_ENTRY_COUNT;

   // op codes the block must treat as no-ops
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   localparam int ITEM_TARGET = 1170;
   localparam int FILL_AT     = 250;            // start of the whole-map claim
   localparam int FILL_OWNER  = 7;
   localparam int PAUSE_AT    = 820;            // sender waits for every result
   localparam int STEADY_FROM = 900;            // window with no sender idling
   localparam int STEADY_TO   = 1050;
   // the cycle limit leaves a wide margin over ~1170 words plus the clearing
   // pass and the idle drops
   localparam int unsigned CYCLE_LIMIT = 4_000_000;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [BLK_W-1:0]    blk;
      logic [OWNER_W-1:0]  owner;
      logic [RES_W-1:0]    res;
      logic [WORD16_W-1:0] value;
      logic [WORD16_W-1:0] flags;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  freed;
      logic [COUNT_W-1:0]  run;
   } rsp_word_type;

   // one row of the directed sequence; 'typed' rows carry a hand-written result
   typedef struct packed {
      req_word_type word;
      logic         typed;
      rsp_word_type want;
   } plan_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_op;
   logic [BLK_W-1:0]    req_block_index;
   logic [OWNER_W-1:0]  req_owner_byte;
   logic [RES_W-1:0]    req_resource_index;
   logic [WORD16_W-1:0] req_entry_value_in;
   logic [WORD16_W-1:0] req_entry_flags_in;
   logic                rsp_strobe;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_freed_count;
   logic [COUNT_W-1:0]  rsp_longest_free_run;

   block_owner_table_engine dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_op               (req_op),
      .req_block_index      (req_block_index),
      .req_owner_byte       (req_owner_byte),
      .req_resource_index   (req_resource_index),
      .req_entry_value_in   (req_entry_value_in),
      .req_entry_flags_in   (req_entry_flags_in),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_freed_count      (rsp_freed_count),
      .rsp_longest_free_run (rsp_longest_free_run)
   );

   // shadow copy of the owner map and entry table
   logic [OWNER_W-1:0]  map_owner  [BLOCKS];
   logic [WORD16_W-1:0] slot_value [ENTRIES];
   logic [WORD16_W-1:0] slot_flags [ENTRIES];

   rsp_word_type awaited_words [$];
   plan_row_type plan [$];
   rsp_word_type exp_word;
   int unsigned  sent_count;
   int unsigned  fault_count;
   int unsigned  cycle_count;
   bit           steady;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung block or a lost result word ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Shadow model
   // ---------------------------------------------------------------------

   function automatic void shadow_reset();
      for (int i = 0; i < BLOCKS; i++) map_owner[i] = FREE_MARK;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_value[i] = '0;
         slot_flags[i] = FLAGS_IDLE;
      end
   endfunction

   // Frees every block held by 'owner'; returns how many were freed.
   function automatic int unsigned free_owner(input logic [OWNER_W-1:0] owner);
      int unsigned n;
      n = 0;
      for (int i = 0; i < BLOCKS; i++) begin
         if (map_owner[i] == owner) begin
            map_owner[i] = FREE_MARK;
            n++;
         end
      end
      return n;
   endfunction

   // Applies one request word to the shadow state and returns the result
   // word the block must produce for it.
   function automatic rsp_word_type apply_table_op(input req_word_type w);
      rsp_word_type r;
      int unsigned  released;
      int unsigned  run;
      int unsigned  best;
      released = 0;
      r = '0;
      r.status = STATUS_OK;
      case (w.op) inside
         OP_WRITE_OWNER: map_owner[w.blk] = w.owner;
         [OP_WRITE_ENTRY:OP_ACTIVATE]: begin
            if (w.res >= ENTRIES) begin
               r.status = STATUS_BAD_IDX;
            end else if (w.op == OP_WRITE_ENTRY) begin
               slot_value[w.res] = w.value;
               slot_flags[w.res] = w.flags;
            end else if (w.op == OP_RELEASE) begin
               released = free_owner(w.res);
               if (released != 0) r.status = STATUS_RELEASED;
            end else if (w.op == OP_RESET_ENTRY) begin
               // acts only on an entry that is not idle; status stays ok
               if (slot_flags[w.res] != FLAGS_IDLE) begin
                  released = free_owner(w.res);
                  slot_flags[w.res] = FLAGS_IDLE;
                  slot_value[w.res] = '0;
               end
            end else if (slot_value[w.res] > ACTIVATE_LIMIT) begin
               // activate: strictly above the limit, status stays ok
               released = free_owner(w.res);
               slot_value[w.res] = 16'd1;
            end
         end
         default: ;  // spare op codes touch nothing
      endcase
      run = 0;
      best = 0;
      for (int i = 0; i < BLOCKS; i++) begin
         if (map_owner[i] == FREE_MARK) begin
            run++;
            if (run > best) best = run;
         end else begin
            run = 0;
         end
      end
      r.freed = (released > COUNT_MAX) ? COUNT_MAX : COUNT_W'(released);
      r.run   = (best > COUNT_MAX) ? COUNT_MAX : COUNT_W'(best);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   function automatic req_word_type make_word(input logic [OP_W-1:0] op,
                                              input int unsigned blk,
                                              input int unsigned owner,
                                              input int unsigned res,
                                              input int unsigned value,
                                              input int unsigned flags);
      req_word_type w;
      w.op    = op;
      w.blk   = BLK_W'(blk);
      w.owner = OWNER_W'(owner);
      w.res   = RES_W'(res);
      w.value = WORD16_W'(value);
      w.flags = WORD16_W'(flags);
      return w;
   endfunction

   function automatic rsp_word_type make_rsp(input logic [STATUS_W-1:0] status,
                                             input int unsigned freed,
                                             input int unsigned run);
      rsp_word_type r;
      r.status = status;
      r.freed  = COUNT_W'(freed);
      r.run    = COUNT_W'(run);
      return r;
   endfunction

   function automatic void add_row(input req_word_type w, input logic typed,
                                   input rsp_word_type want);
      plan_row_type row;
      row.word  = w;
      row.typed = typed;
      row.want  = want;
      plan.push_back(row);
   endfunction

   function automatic void build_plan();
      rsp_word_type none;
      none = '0;
      // fresh state: spare ops, bad indexes, idle entries
      add_row(make_word(OP_SPARE_LO, 0, 0, 0, 0, 0), 1'b1, make_rsp(STATUS_OK, 0, 512));
      add_row(make_word(OP_SPARE_HI, 0, 0, 0, 0, 0), 1'b1, make_rsp(STATUS_OK, 0, 512));
      add_row(make_word(OP_WRITE_ENTRY, 0, 0, 96, 16'h1234, 0), 1'b1,
              make_rsp(STATUS_BAD_IDX, 0, 512));
      add_row(make_word(OP_RELEASE, 0, 0, 255, 0, 0), 1'b1,
              make_rsp(STATUS_BAD_IDX, 0, 512));
      add_row(make_word(OP_ACTIVATE, 0, 0, 200, 0, 0), 1'b1,
              make_rsp(STATUS_BAD_IDX, 0, 512));
      add_row(make_word(OP_RESET_ENTRY, 0, 0, 0, 0, 0), 1'b1, make_rsp(STATUS_OK, 0, 512));
      add_row(make_word(OP_ACTIVATE, 0, 0, 0, 0, 0), 1'b1, make_rsp(STATUS_OK, 0, 512));
      add_row(make_word(OP_RELEASE, 0, 0, 0, 0, 0), 1'b1, make_rsp(STATUS_OK, 0, 512));
      // owner writes at both ends and the middle, then release
      add_row(make_word(OP_WRITE_OWNER, 0, 3, 0, 0, 0), 1'b1, make_rsp(STATUS_OK, 0, 511));
      add_row(make_word(OP_WRITE_OWNER, 511, 3, 0, 0, 0), 1'b1,
              make_rsp(STATUS_OK, 0, 510));
      add_row(make_word(OP_WRITE_OWNER, 256, 3, 0, 0, 0), 1'b1,
              make_rsp(STATUS_OK, 0, 255));
      add_row(make_word(OP_WRITE_OWNER, 300, FREE_MARK, 0, 0, 0), 1'b0, none);
      add_row(make_word(OP_RELEASE, 0, 0, 3, 0, 0), 1'b1, make_rsp(STATUS_RELEASED, 3, 512));
      // activate just above and at the limit
      add_row(make_word(OP_WRITE_ENTRY, 0, 0, 5, 17, 0), 1'b0, none);
      add_row(make_word(OP_WRITE_OWNER, 10, 5, 0, 0, 0), 1'b0, none);
      add_row(make_word(OP_WRITE_OWNER, 11, 5, 0, 0, 0), 1'b0, none);
      add_row(make_word(OP_WRITE_OWNER, 40, 6, 0, 0, 0), 1'b0, none);
      add_row(make_word(OP_ACTIVATE, 0, 0, 5, 0, 0), 1'b0, none);
      add_row(make_word(OP_ACTIVATE, 0, 0, 5, 0, 0), 1'b0, none);
      add_row(make_word(OP_WRITE_ENTRY, 0, 0, 5, 16, 16'h1234), 1'b0, none);
      add_row(make_word(OP_WRITE_OWNER, 20, 5, 0, 0, 0), 1'b0, none);
      add_row(make_word(OP_ACTIVATE, 0, 0, 5, 0, 0), 1'b0, none);
      add_row(make_word(OP_RESET_ENTRY, 0, 0, 5, 0, 0), 1'b0, none);
      add_row(make_word(OP_RESET_ENTRY, 0, 0, 5, 0, 0), 1'b0, none);
      // last valid entry
      add_row(make_word(OP_WRITE_ENTRY, 0, 0, 95, 16'hFFFF, 16'hFFFE), 1'b0, none);
      add_row(make_word(OP_WRITE_OWNER, 100, 95, 0, 0, 0), 1'b0, none);
      add_row(make_word(OP_RESET_ENTRY, 0, 0, 95, 0, 0), 1'b0, none);
      add_row(make_word(OP_ACTIVATE, 0, 0, 95, 0, 0), 1'b0, none);
      add_row(make_word(OP_RELEASE, 0, 0, 6, 0, 0), 1'b0, none);
      add_row(make_word(OP_WRITE_ENTRY, 0, 0, 0, 17, 16'hFFFF), 1'b0, none);
      add_row(make_word(OP_ACTIVATE, 0, 0, 0, 0, 0), 1'b0, none);
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int unsigned  pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      w.op = OP_WRITE_OWNER;
      else if (pick < 50) w.op = OP_WRITE_ENTRY;
      else if (pick < 65) w.op = OP_RELEASE;
      else if (pick < 77) w.op = OP_RESET_ENTRY;
      else if (pick < 90) w.op = OP_ACTIVATE;
      else                w.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      w.blk = BLK_W'($urandom);
      // owners cluster on a few low ids so releases find blocks
      pick = $urandom_range(0, 3);
      if (pick == 0)      w.owner = FREE_MARK;
      else if (pick == 3) w.owner = OWNER_W'($urandom);
      else                w.owner = OWNER_W'($urandom_range(0, 15));
      pick = $urandom_range(0, 3);
      if (pick == 0)      w.res = RES_W'($urandom);
      else if (pick == 1) w.res = RES_W'($urandom_range(0, ENTRIES - 1));
      else                w.res = RES_W'($urandom_range(0, 15));
      w.value = $urandom_range(0, 1) ? WORD16_W'($urandom)
                                     : WORD16_W'($urandom_range(0, 32));
      w.flags = ($urandom_range(0, 3) == 0) ? FLAGS_IDLE : WORD16_W'($urandom);
      return w;
   endfunction

   task automatic drive_req(input logic go, input req_word_type w);
      start              <= go;
      req_op             <= w.op;
      req_block_index    <= w.blk;
      req_owner_byte     <= w.owner;
      req_resource_index <= w.res;
      req_entry_value_in <= w.value;
      req_entry_flags_in <= w.flags;
   endtask

   // Presents one word until it is taken; drops start now and then.
   task automatic send_word(input req_word_type w, input logic typed,
                            input rsp_word_type want);
      rsp_word_type pred;
      logic         idle;
      logic         taken;
      taken = 1'b0;
      while (!taken) begin
         idle = !steady && ($urandom_range(0, 99) < 25);
         drive_req(!idle, w);
         @(posedge clock);
         taken = start && !busy;
      end
      pred = apply_table_op(w);
      awaited_words.push_back(typed ? want : pred);
      sent_count++;
   endtask

   initial begin
      rsp_word_type none;
      none   = '0;
      steady = 1'b0;
      reset  = 1'b1;
      drive_req(1'b0, '0);
      shadow_reset();
      build_plan();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want);
      while (sent_count < ITEM_TARGET) begin
         steady = (sent_count >= STEADY_FROM) && (sent_count < STEADY_TO);
         if (sent_count == FILL_AT) begin
            // every block to one owner, then free them all in one release
            for (int b = 0; b < BLOCKS; b++) begin
               send_word(make_word(OP_WRITE_OWNER, b, FILL_OWNER, 0, 0, 0), 1'b0, none);
            end
            send_word(make_word(OP_RELEASE, 0, 0, FILL_OWNER, 0, 0), 1'b1,
                      make_rsp(STATUS_RELEASED, BLOCKS, BLOCKS));
         end else if (sent_count == PAUSE_AT) begin
            drive_req(1'b0, '0);
            do @(posedge clock); while (awaited_words.size() != 0);
            send_word(random_word(), 1'b0, none);
         end else begin
            send_word(random_word(), 1'b0, none);
         end
      end
      drive_req(1'b0, '0);
      while (awaited_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (fault_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (awaited_words.size() == 0) begin
            $error("result word with no request outstanding");
            fault_count++;
         end else begin
            exp_word = awaited_words.pop_front();
            if (rsp_status !== exp_word.status) begin
               $error("status: expected %0d, actual %0d", exp_word.status, rsp_status);
               fault_count++;
            end
            if (rsp_freed_count !== exp_word.freed) begin
               $error("freed_count: expected %0d, actual %0d",
                      exp_word.freed, rsp_freed_count);
               fault_count++;
            end
            if (rsp_longest_free_run !== exp_word.run) begin
               $error("longest_free_run: expected %0d, actual %0d",
                      exp_word.run, rsp_longest_free_run);
               fault_count++;
            end
         end
      end
   end

endmodule
